### design/hasv_pkg.sv
// Shared types, widths and elaboration-time constants for the haversine separation unit.
// The arctangent table and the CORDIC gain are derived here with integer series.
// Depends on nothing.
package hasv_pkg;

  localparam int ANGLE_BITS    = 32;
  localparam int CORDIC_STAGES = 30;
  localparam int UP_BITS       = 64 - ANGLE_BITS;
  localparam int Q_BITS        = 30;
  localparam int XW            = 34;
  localparam int ZW            = 64;
  localparam int HAV_W         = 61;
  localparam int ROOT_W        = 31;
  localparam int REM_W         = 63;
  localparam int LANES         = 4;

  localparam logic [63:0] ONE60 = 64'd1 << 60;

  typedef logic [63:0] atan_tab_t [CORDIC_STAGES];

  typedef struct packed {
    logic signed [XW-1:0] cos_first;
    logic signed [XW-1:0] cos_second;
    logic signed [XW-1:0] sin_dlat;
    logic signed [XW-1:0] sin_dlon;
  } trig_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root_hav;
    logic [ROOT_W-1:0] root_comp;
  } roots_t;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inverse(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] t;
    p   = udiv(ONE60, n);
    nn  = n * n;
    sum = '0;
    k   = '0;
    while (p != 64'd0) begin
      t = udiv(p, 64'd2 * k + 64'd1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      p = udiv(p, nn);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] t;
    int sh;
    p   = (i < 61) ? (ONE60 >> i) : 64'd0;
    sum = '0;
    k   = '0;
    sh  = 2 * i;
    while (p != 64'd0) begin
      t = udiv(p, 64'd2 * k + 64'd1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      p = (sh < 61) ? (p >> sh) : 64'd0;
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    logic [63:0] pi60;
    logic [63:0] twopi;
    logic [63:0] r;
    logic [63:0] q;
    pi60  = 64'd4 * (64'd4 * atan_inverse(64'd5) - atan_inverse(64'd239));
    twopi = 64'd2 * pi60;
    tab[0] = 64'd1 << 61;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      r = atan_pow2(i);
      q = '0;
      for (int b = 0; b < 64; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= twopi) begin
          r = r - twopi;
          q = q | 64'd1;
        end
      end
      tab[i] = q;
    end
    return tab;
  endfunction

  function automatic logic [63:0] build_gain();
    logic [63:0] k2;
    int sh;
    k2 = ONE60;
    for (int b = 0; b < CORDIC_STAGES; b++) begin
      sh = 2 * b;
      if (sh < 62) k2 = k2 - udiv(k2, (64'd1 << sh) + 64'd1);
    end
    return isqrt64(k2);
  endfunction

  localparam atan_tab_t   ATAN_TAB    = build_atan_tab();
  localparam logic [63:0] CORDIC_GAIN = build_gain();

endpackage

### design/hasv_if.sv
// Handshake channels of the haversine separation unit: the point-pair input and the result.
// Depends on nothing.
interface hasv_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] first_longitude;
  logic signed [31:0] first_latitude;
  logic        [31:0] second_longitude;
  logic signed [31:0] second_latitude;

  modport source (output valid, first_longitude, first_latitude, second_longitude,
                  second_latitude, input ready);
  modport sink (input valid, first_longitude, first_latitude, second_longitude,
                second_latitude, output ready);
endinterface

interface hasv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] separation;

  modport source (output valid, separation, input ready);
  modport sink (input valid, separation, output ready);
endinterface

### design/hasv_rot_cordic.sv
// Four-lane rotation CORDIC pipeline giving the cosines and sines that the haversine needs.
// Depends on hasv_pkg.
module hasv_rot_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          ph [hasv_pkg::LANES],
  output logic                 out_valid,
  output hasv_pkg::trig_t      trig
);

  localparam int N = hasv_pkg::CORDIC_STAGES;
  localparam int L = hasv_pkg::LANES;
  localparam int XW = hasv_pkg::XW;
  localparam int ZW = hasv_pkg::ZW;

  logic                 v_r [N];
  logic signed [XW-1:0] x_r [N][L];
  logic signed [XW-1:0] y_r [N][L];
  logic signed [ZW-1:0] z_r [N][L];
  logic [1:0]           q_r [N][L];
  logic signed [XW-1:0] cos_o [L];
  logic signed [XW-1:0] sin_o [L];

  for (genvar k = 0; k < N; k++) begin : g_stage
    for (genvar l = 0; l < L; l++) begin : g_lane
      logic signed [XW-1:0] xi, yi, x_nxt, y_nxt;
      logic signed [ZW-1:0] zi, z_nxt;
      logic [1:0]           qi;

      if (k == 0) begin : g_init
        assign xi = XW'(hasv_pkg::CORDIC_GAIN);
        assign yi = '0;
        assign zi = {2'b00, ph[l][61:0]};
        assign qi = ph[l][63:62];
      end else begin : g_chain
        assign xi = x_r[k-1][l];
        assign yi = y_r[k-1][l];
        assign zi = z_r[k-1][l];
        assign qi = q_r[k-1][l];
      end

      always_comb begin
        if (!zi[ZW-1]) begin
          x_nxt = xi - (yi >>> k);
          y_nxt = yi + (xi >>> k);
          z_nxt = zi - ZW'(hasv_pkg::ATAN_TAB[k]);
        end else begin
          x_nxt = xi + (yi >>> k);
          y_nxt = yi - (xi >>> k);
          z_nxt = zi + ZW'(hasv_pkg::ATAN_TAB[k]);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k][l] <= x_nxt;
          y_r[k][l] <= y_nxt;
          z_r[k][l] <= z_nxt;
          q_r[k][l] <= qi;
        end
      end
    end

    if (k == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= in_valid;
        end
      end
    end else begin : g_vk
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Fold the quadrant back in: the CORDIC only covered the first quarter turn.
  for (genvar l = 0; l < L; l++) begin : g_quad
    always_comb begin
      case (q_r[N-1][l])
        2'd0: begin
          cos_o[l] = x_r[N-1][l];
          sin_o[l] = y_r[N-1][l];
        end
        2'd1: begin
          cos_o[l] = -y_r[N-1][l];
          sin_o[l] = x_r[N-1][l];
        end
        2'd2: begin
          cos_o[l] = -x_r[N-1][l];
          sin_o[l] = -y_r[N-1][l];
        end
        default: begin
          cos_o[l] = y_r[N-1][l];
          sin_o[l] = -x_r[N-1][l];
        end
      endcase
    end
  end

  assign out_valid       = v_r[N-1];
  assign trig.cos_first  = cos_o[0];
  assign trig.cos_second = cos_o[1];
  assign trig.sin_dlat   = sin_o[2];
  assign trig.sin_dlon   = sin_o[3];

endmodule

### design/hasv_hav.sv
// Multiplier stages that form the haversine value and clamp it to the range zero to one.
// Depends on hasv_pkg.
module hasv_hav (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  hasv_pkg::trig_t             trig,
  output logic                        out_valid,
  output logic [hasv_pkg::HAV_W-1:0]  hav
);

  localparam int XW = hasv_pkg::XW;
  localparam int PW = 2 * XW;
  localparam int TW = XW;
  localparam int P2W = TW + XW;
  localparam int T2W = XW;
  localparam int P3W = T2W + XW;
  localparam int SW = P3W + 1;
  localparam int HW = hasv_pkg::HAV_W;

  logic [3:0]            v_r;
  logic signed [PW-1:0]  p12_r;
  logic signed [PW-1:0]  sd2_r [3];
  logic signed [XW-1:0]  sl_r [2];
  logic signed [P2W-1:0] p2_r;
  logic signed [P3W-1:0] p3_r;
  logic [HW-1:0]         hav_r;
  logic signed [TW-1:0]  t1;
  logic signed [T2W-1:0] t2;
  logic signed [SW-1:0]  sum;
  logic [HW-1:0]         hav_nxt;

  assign t1  = TW'(p12_r >>> hasv_pkg::Q_BITS);
  assign t2  = T2W'(p2_r >>> hasv_pkg::Q_BITS);
  assign sum = SW'(sd2_r[2]) + SW'(p3_r);

  always_comb begin
    if (sum[SW-1]) begin
      hav_nxt = '0;
    end else if ((|sum[SW-2:HW]) || (sum[HW-1] && (|sum[HW-2:0]))) begin
      hav_nxt = HW'(hasv_pkg::ONE60);
    end else begin
      hav_nxt = sum[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p12_r    <= trig.cos_first * trig.cos_second;
      sd2_r[0] <= trig.sin_dlat * trig.sin_dlat;
      sl_r[0]  <= trig.sin_dlon;
      p2_r     <= t1 * sl_r[0];
      sd2_r[1] <= sd2_r[0];
      sl_r[1]  <= sl_r[0];
      p3_r     <= t2 * sl_r[1];
      sd2_r[2] <= sd2_r[1];
      hav_r    <= hav_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  assign out_valid = v_r[3];
  assign hav       = hav_r;

endmodule

### design/hasv_isqrt.sv
// Two-lane digit-by-digit square root pipeline for sqrt(hav) and sqrt(1 - hav).
// Depends on hasv_pkg.
module hasv_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [hasv_pkg::HAV_W-1:0]  hav,
  output logic                        out_valid,
  output hasv_pkg::roots_t            roots
);

  localparam int RW = hasv_pkg::ROOT_W;
  localparam int MW = hasv_pkg::REM_W;
  localparam int HW = hasv_pkg::HAV_W;

  logic          v_r [RW];
  logic [MW-1:0] rem_r [RW][2];
  logic [RW-1:0] root_r [RW][2];
  logic [HW-1:0] comp;

  assign comp = HW'(hasv_pkg::ONE60) - hav;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [MW-1:0] ri, trial, rem_nxt;
      logic [RW-1:0] qi, root_nxt;

      if (k == 0) begin : g_init
        assign ri = (l == 0) ? MW'(hav) : MW'(comp);
        assign qi = '0;
      end else begin : g_chain
        assign ri = rem_r[k-1][l];
        assign qi = root_r[k-1][l];
      end

      assign trial = (MW'(qi) << (B + 1)) + (MW'(1) << (2 * B));

      always_comb begin
        if (ri >= trial) begin
          rem_nxt  = ri - trial;
          root_nxt = qi | (RW'(1) << B);
        end else begin
          rem_nxt  = ri;
          root_nxt = qi;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l]  <= rem_nxt;
          root_r[k][l] <= root_nxt;
        end
      end
    end

    if (k == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= in_valid;
        end
      end
    end else begin : g_vk
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign out_valid       = v_r[RW-1];
  assign roots.root_hav  = root_r[RW-1][0];
  assign roots.root_comp = root_r[RW-1][1];

endmodule

### design/hasv_vec_cordic.sv
// Vectoring CORDIC pipeline that turns the two square roots into the half separation angle.
// Depends on hasv_pkg.
module hasv_vec_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  hasv_pkg::roots_t               roots,
  output logic                           out_valid,
  output logic signed [hasv_pkg::ZW-1:0] angle
);

  localparam int N = hasv_pkg::CORDIC_STAGES;
  localparam int XW = hasv_pkg::XW;
  localparam int ZW = hasv_pkg::ZW;

  logic                 v_r [N];
  logic signed [XW-1:0] x_r [N];
  logic signed [XW-1:0] y_r [N];
  logic signed [ZW-1:0] z_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [XW-1:0] xi, yi, x_nxt, y_nxt;
    logic signed [ZW-1:0] zi, z_nxt;

    if (k == 0) begin : g_init
      assign xi = XW'(roots.root_comp);
      assign yi = XW'(roots.root_hav);
      assign zi = '0;
    end else begin : g_chain
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
    end

    always_comb begin
      if (!yi[XW-1]) begin
        x_nxt = xi + (yi >>> k);
        y_nxt = yi - (xi >>> k);
        z_nxt = zi + ZW'(hasv_pkg::ATAN_TAB[k]);
      end else begin
        x_nxt = xi - (yi >>> k);
        y_nxt = yi + (xi >>> k);
        z_nxt = zi - ZW'(hasv_pkg::ATAN_TAB[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= x_nxt;
        y_r[k] <= y_nxt;
        z_r[k] <= z_nxt;
      end
    end

    if (k == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= in_valid;
        end
      end
    end else begin : g_vk
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign angle     = z_r[N-1];

endmodule

### design/haversine_angular_separation_unit.sv
// Throughput: one item per cycle while the output buffer has room, set by the fully pipelined
// CORDIC and square root stages. A two-entry output buffer lets the pipeline keep taking items
// while a result waits.
// Reset (rst_n, synchronous, active low) clears all valid bits, those of the output buffer too.
// Depends on hasv_pkg, hasv_if and the hasv_* pipeline modules.
module haversine_angular_separation_unit (
  input  logic       clk,
  input  logic       rst_n,
  hasv_in_if.sink    in_chan,
  hasv_out_if.source out_chan
);

  localparam int AB = hasv_pkg::ANGLE_BITS;
  localparam int UP = hasv_pkg::UP_BITS;
  localparam int ZW = hasv_pkg::ZW;

  logic                 en;
  logic                 v0_r;
  logic [63:0]          ph_r [hasv_pkg::LANES];
  logic [63:0]          lon1, lat1, lon2, lat2, dlat, dlon;
  logic                 rot_v, hav_v, sq_v, vec_v;
  hasv_pkg::trig_t      trig;
  logic [hasv_pkg::HAV_W-1:0] hav;
  hasv_pkg::roots_t     roots;
  logic signed [ZW-1:0] angle;
  logic [62:0]          zc;
  logic [63:0]          sep64;
  logic [31:0]          sep;
  logic                 arrive;
  logic                 out_valid_r, skid_valid_r;
  logic [31:0]          out_data_r, skid_data_r;

  assign en = !skid_valid_r;
  assign in_chan.ready = en;

  assign lon1 = {in_chan.first_longitude[AB-1:0], UP'(0)};
  assign lat1 = {in_chan.first_latitude[AB-1:0], UP'(0)};
  assign lon2 = {in_chan.second_longitude[AB-1:0], UP'(0)};
  assign lat2 = {in_chan.second_latitude[AB-1:0], UP'(0)};
  assign dlat = lat1 - lat2;
  assign dlon = lon1 - lon2;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r[0] <= lat1;
      ph_r[1] <= lat2;
      ph_r[2] <= {dlat[63], dlat[63:1]};
      ph_r[3] <= {dlon[63], dlon[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid;
    end
  end

  hasv_rot_cordic u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .ph        (ph_r),
    .out_valid (rot_v),
    .trig      (trig)
  );

  hasv_hav u_hav (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rot_v),
    .trig      (trig),
    .out_valid (hav_v),
    .hav       (hav)
  );

  hasv_isqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (hav_v),
    .hav       (hav),
    .out_valid (sq_v),
    .roots     (roots)
  );

  hasv_vec_cordic u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .roots     (roots),
    .out_valid (vec_v),
    .angle     (angle)
  );

  // The half angle is kept within a quarter turn before it is doubled and rounded.
  always_comb begin
    if (angle[ZW-1]) begin
      zc = '0;
    end else if (angle[62] && (|angle[61:0])) begin
      zc = 63'd1 << 62;
    end else begin
      zc = angle[62:0];
    end
  end

  assign sep64  = {zc, 1'b0} + (64'd1 << (UP - 1));
  assign sep    = 32'(sep64 >> UP);
  assign arrive = en && vec_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= arrive;
      end
    end else if (arrive) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : sep;
    end else if (arrive) begin
      skid_data_r <= sep;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.separation = out_data_r;

endmodule

### sim/haversine_angular_separation_unit_tb.sv
// Self-checking testbench for the haversine separation unit: point pairs go in, separations
// come out and are compared with a fixed-point CORDIC predictor held in the bench.
// Depends on hasv_pkg, hasv_if and the unit itself.
module haversine_angular_separation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES      = hasv_pkg::CORDIC_STAGES;
  localparam int SHIFT_UP    = 64 - hasv_pkg::ANGLE_BITS;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned Q60 = 64'd1 << 60;

  typedef struct {
    logic [31:0] lon_a;
    logic [31:0] lat_a;
    logic [31:0] lon_b;
    logic [31:0] lat_b;
    bit          known;
    logic [31:0] sep;
  } pair_row_t;

  logic clk;
  logic rst_n;

  hasv_in_if  pair_chan ();
  hasv_out_if sep_chan ();

  haversine_angular_separation_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pair_chan),
    .out_chan (sep_chan)
  );

  longint unsigned arc_tab [STAGES];
  longint          gain_q30;
  logic [31:0]     sep_queue [$];
  int              fail_count;
  int              quiet_cycles;
  int              send_idle;
  int              recv_stall;
  bit              hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned series_atan(input longint unsigned first,
                                                  input longint unsigned ratio,
                                                  input bit by_shift);
    longint unsigned p, sum, k, t;
    p = first;
    sum = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      sum = k[0] ? sum - t : sum + t;
      if (by_shift) p = (ratio < 61) ? (p >> ratio) : 0;
      else p = p / ratio;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned acc, probe, rest;
    acc = 0;
    rest = v;
    probe = 64'd1 << 62;
    while (probe > rest) probe >>= 2;
    while (probe != 0) begin
      if (rest >= acc + probe) begin
        rest -= acc + probe;
        acc = (acc >> 1) + probe;
      end else begin
        acc >>= 1;
      end
      probe >>= 2;
    end
    return acc;
  endfunction

  function automatic void make_tables();
    longint unsigned pi60, turn, r, q, k2;
    pi60 = 4 * (4 * series_atan(Q60 / 5, 25, 0) - series_atan(Q60 / 239, 239 * 239, 0));
    turn = 2 * pi60;
    arc_tab[0] = 64'd1 << 61;
    for (int i = 1; i < STAGES; i++) begin
      r = series_atan((i < 61) ? (Q60 >> i) : 0, 2 * i, 1);
      q = 0;
      for (int b = 0; b < 64; b++) begin
        r <<= 1;
        q <<= 1;
        if (r >= turn) begin
          r -= turn;
          q |= 1;
        end
      end
      arc_tab[i] = q;
    end
    k2 = Q60;
    for (int b = 0; b < STAGES; b++)
      if (2 * b < 62) k2 -= k2 / ((64'd1 << (2 * b)) + 1);
    gain_q30 = longint'(root_floor(k2));
  endfunction

  function automatic void rotate(input longint unsigned ph, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = gain_q30;
    y = 0;
    z = longint'(ph & ((64'd1 << 62) - 1));
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arc_tab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(arc_tab[i]);
      end
    end
    case (ph[63:62])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [31:0] great_circle(input pair_row_t p);
    longint unsigned lo1, la1, lo2, la2, d;
    longint c1, s1, c2, s2, cd, sd, cl, sl, t, hav, x, y, z, dx, dy;
    longint unsigned sep;
    lo1 = 64'(p.lon_a) << SHIFT_UP;
    la1 = 64'(p.lat_a) << SHIFT_UP;
    lo2 = 64'(p.lon_b) << SHIFT_UP;
    la2 = 64'(p.lat_b) << SHIFT_UP;
    rotate(la1, c1, s1);
    rotate(la2, c2, s2);
    d = la1 - la2;
    rotate(longint'(d) >>> 1, cd, sd);
    d = lo1 - lo2;
    rotate(longint'(d) >>> 1, cl, sl);
    t = (c1 * c2) >>> 30;
    t = (t * sl) >>> 30;
    hav = sd * sd + t * sl;
    if (hav < 0) hav = 0;
    if (hav > longint'(Q60)) hav = longint'(Q60);
    y = longint'(root_floor(hav));
    x = longint'(root_floor(Q60 - hav));
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(arc_tab[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(arc_tab[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(64'd1 << 62)) z = longint'(64'd1 << 62);
    sep = (unsigned'(z) << 1) + (64'd1 << (SHIFT_UP - 1));
    return 32'(sep >> SHIFT_UP);
  endfunction

  task automatic send_pair(input pair_row_t p);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      pair_chan.valid <= 1'b0;
      @(posedge clk);
    end
    pair_chan.valid            <= 1'b1;
    pair_chan.first_longitude  <= p.lon_a;
    pair_chan.first_latitude   <= p.lat_a;
    pair_chan.second_longitude <= p.lon_b;
    pair_chan.second_latitude  <= p.lat_b;
    do @(posedge clk); while (!pair_chan.ready);
    sep_queue.push_back(p.known ? p.sep : great_circle(p));
  endtask

  function automatic logic [31:0] any_lat(input bit wild);
    if (wild) return $urandom;
    return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
  endfunction

  function automatic pair_row_t random_pair();
    pair_row_t p;
    int mode;
    mode = $urandom_range(9);
    p.known = 1'b0;
    p.sep = '0;
    p.lon_a = $urandom;
    p.lat_a = any_lat(mode == 0);
    if (mode < 4) begin
      p.lon_b = $urandom;
      p.lat_b = any_lat(mode == 1);
    end else begin
      // Nearby points stress the small-angle end of the square root and arctangent.
      p.lon_b = p.lon_a + 32'($urandom_range(2048)) - 32'd1024;
      p.lat_b = p.lat_a + 32'($urandom_range(1 << (mode + 8))) - 32'(1 << (mode + 7));
    end
    return p;
  endfunction

  pair_row_t directed [] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 1'b0, 32'h0},
    '{32'h1234_5678, 32'hC000_0000, 32'h1234_5678, 32'hC000_0000, 1'b0, 32'h0},
    '{32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b0, 32'h0},
    '{32'h0, 32'h4000_0000, 32'h0, 32'hC000_0000, 1'b0, 32'h0},
    '{32'h0, 32'h0, 32'h4000_0000, 32'h0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{32'h4000_0000, 32'h5000_0000, 32'hC000_0000, 32'hB000_0000, 1'b0, 32'h0},
    '{32'h0, 32'h3FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF, 1'b0, 32'h0},
    '{32'h8000_0000, 32'h0, 32'h8000_0001, 32'h1, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 32'h2AAA_AAAA, 32'h5555_5555, 32'hD555_5555, 1'b0, 32'h0},
    '{32'h0, 32'hC000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 1'b0, 32'h0}
  };

  initial begin
    sep_chan.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        sep_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      sep_chan.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && sep_chan.valid && sep_chan.ready) begin
      if (sep_queue.size() == 0) begin
        $error("separation: unexpected item, actual %h", sep_chan.separation);
        fail_count++;
      end else if (sep_chan.separation !== sep_queue[0]) begin
        $error("separation: expected %h, actual %h", sep_queue[0], sep_chan.separation);
        fail_count++;
        void'(sep_queue.pop_front());
      end else begin
        void'(sep_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pair_chan.valid && pair_chan.ready) || (sep_chan.valid && sep_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    static int send_rates [4] = '{0, 50, 0, 27};
    static int stall_rates [4] = '{0, 0, 50, 27};
    rst_n <= 1'b0;
    pair_chan.valid <= 1'b0;
    pair_chan.first_longitude <= '0;
    pair_chan.first_latitude <= '0;
    pair_chan.second_longitude <= '0;
    pair_chan.second_latitude <= '0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    make_tables();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pair(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = send_rates[ph];
      recv_stall = stall_rates[ph];
      // The first phase starts with a long output stall so that the pipeline backs up.
      if (ph == 0) hold_req = 1'b1;
      repeat (350) send_pair(random_pair());
      pair_chan.valid <= 1'b0;
      wait (sep_queue.size() == 0);
      @(posedge clk);
    end

    repeat (120) @(posedge clk);
    if (fail_count == 0 && sep_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
